### rtl/core/cde_pkg.sv
// Shared types and constants for the civil date to epoch converter.
`timescale 1ns / 1ps

package cde_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] MIN_YEAR     = 16'd2000;
  localparam logic [7:0]  MONTHS       = 8'd12;
  localparam logic [7:0]  MAX_HOUR     = 8'd23;
  localparam logic [7:0]  MAX_MINSEC   = 8'd59;
  localparam logic [7:0]  MAX_WEEKDAY  = 8'd6;

  // Divisibility by 25 through the modular inverse: x*inv mod 2^n <= (2^n-1)/25
  localparam logic [13:0] INV25_14     = 14'd7209;
  localparam logic [13:0] LIM25_14     = 14'd655;
  localparam logic [11:0] INV25_12     = 12'd3113;
  localparam logic [11:0] LIM25_12     = 12'd163;

  // floor(x/25) for x < 2^14 as (x * RECIP25) >> RECIP25_SH
  localparam logic [13:0] RECIP25      = 14'd10486;
  localparam int unsigned RECIP25_SH   = 18;

  localparam logic [8:0]  DAYS_YEAR    = 9'd365;
  localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
  localparam logic [16:0] DAY_SECONDS  = 17'd86400;
  localparam logic [11:0] HOUR_SECONDS = 12'd3600;
  localparam logic [5:0]  MIN_SECONDS  = 6'd60;

  localparam int unsigned EPOCH_W = 41;
  localparam int unsigned DAYS_W  = 25;
  localparam int unsigned TOD_W   = 17;

  // One classified request between front and back.
  typedef struct packed {
    logic        ok;
    logic [15:0] year;    // March-based year
    logic [8:0]  doy;     // day of that year, from March 1
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } item_t;

  // Days in a month, month 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Offset of the month's first day in a year that starts in March.
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] o;
    unique case (month)
      4'd1:    o = 9'd306;
      4'd2:    o = 9'd337;
      4'd3:    o = 9'd0;
      4'd4:    o = 9'd31;
      4'd5:    o = 9'd61;
      4'd6:    o = 9'd92;
      4'd7:    o = 9'd122;
      4'd8:    o = 9'd153;
      4'd9:    o = 9'd184;
      4'd10:   o = 9'd214;
      4'd11:   o = 9'd245;
      4'd12:   o = 9'd275;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage

### rtl/core/civil_datetime_to_epoch.sv
// Top level: UTC calendar date and time to Unix epoch seconds.
`timescale 1ns / 1ps

// Takes one request per clock while busy is low and returns one result per
// request, in order. The result strobe out_valid follows the edge that took the
// request through the queue, which hands it on in the next cycle, and the back
// end's three register stages (divide-free year terms, day count,
// the day-by-86400 multiply). The receiver cannot stall, so the queue drains
// every cycle and busy stays low in normal use. A request with any field out
// of range, a year below 2000 or a day past the end of its month gives
// out_status 1 and zero seconds; the weekday is range checked only.
module civil_datetime_to_epoch #(
  parameter int unsigned QUEUE_DEPTH = cde_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [15:0]                 in_year,
  input  logic [7:0]                  in_month,
  input  logic [7:0]                  in_day,
  input  logic [7:0]                  in_hour,
  input  logic [7:0]                  in_minute,
  input  logic [7:0]                  in_second,
  input  logic [7:0]                  in_weekday,
  output logic                        out_valid,
  output logic                        out_status,
  output logic [cde_pkg::EPOCH_W-1:0] out_epoch_seconds
);
  import cde_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  q_empty, q_full;
  logic  push, pop;

  assign busy = q_full;
  assign push = start && !q_full;
  assign pop  = !q_empty;

  cde_front u_front (
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .in_hour    (in_hour),
    .in_minute  (in_minute),
    .in_second  (in_second),
    .in_weekday (in_weekday),
    .item       (front_item)
  );

  cde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (queue_item),
    .empty   (q_empty),
    .full    (q_full)
  );

  cde_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (pop),
    .in_item           (queue_item),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule

### rtl/core/cde_front.sv
// Front end: range checks, leap year test and day-of-year for one request.
`timescale 1ns / 1ps

module cde_front (
  input  logic [15:0]    in_year,
  input  logic [7:0]     in_month,
  input  logic [7:0]     in_day,
  input  logic [7:0]     in_hour,
  input  logic [7:0]     in_minute,
  input  logic [7:0]     in_second,
  input  logic [7:0]     in_weekday,
  output cde_pkg::item_t item
);
  import cde_pkg::*;

  logic [13:0] y4;
  logic [11:0] y16;
  logic [27:0] p4;
  logic [23:0] p16;
  logic        div4, div100, div400, leap;
  logic [3:0]  mon;
  logic        range_ok, day_ok;

  assign y4  = in_year[15:2];
  assign y16 = in_year[15:4];
  assign p4  = 28'(y4) * 28'(INV25_14);
  assign p16 = 24'(y16) * 24'(INV25_12);

  assign div4   = (in_year[1:0] == 2'b00);
  assign div100 = div4 && (p4[13:0] <= LIM25_14);
  assign div400 = (in_year[3:0] == 4'b0000) && (p16[11:0] <= LIM25_12);
  assign leap   = (div4 && !div100) || div400;

  assign mon = in_month[3:0];

  assign range_ok = (in_year >= MIN_YEAR) && (in_month != 8'd0) && (in_month <= MONTHS) &&
                    (in_day != 8'd0) && (in_hour <= MAX_HOUR) &&
                    (in_minute <= MAX_MINSEC) && (in_second <= MAX_MINSEC) &&
                    (in_weekday <= MAX_WEEKDAY);
  assign day_ok   = (in_day <= 8'(month_days(mon, leap)));

  always_comb begin
    item.ok     = range_ok && day_ok;
    // January and February belong to the previous March-based year
    item.year   = (mon <= 4'd2) ? in_year - 16'd1 : in_year;
    item.doy    = month_start(mon) + 9'(in_day[4:0]) - 9'd1;
    item.hour   = in_hour[4:0];
    item.minute = in_minute[5:0];
    item.second = in_second[5:0];
  end

endmodule

### rtl/core/cde_fifo.sv
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module cde_fifo #(
  parameter int unsigned DEPTH = cde_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cde_pkg::item_t wr_item,
  input  logic           pop,
  output cde_pkg::item_t rd_item,
  output logic           empty,
  output logic           full
);
  import cde_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("request pushed into full queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not track push");
`endif

endmodule

### rtl/core/cde_back.sv
// Back end: day count, time of day and epoch seconds in three stages.
`timescale 1ns / 1ps

module cde_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  cde_pkg::item_t                  in_item,
  output logic                            out_valid,
  output logic                            out_status,
  output logic [cde_pkg::EPOCH_W-1:0]     out_epoch_seconds
);
  import cde_pkg::*;

  // stage 1
  logic               s1_valid_r;
  logic               s1_ok_r;
  logic [13:0]        s1_y4_r;
  logic [9:0]         s1_q100_r;
  logic [DAYS_W-1:0]  s1_d365_r;
  logic [8:0]         s1_doy_r;
  logic [TOD_W-1:0]   s1_tod_r;
  // stage 2
  logic               s2_valid_r;
  logic               s2_ok_r;
  logic [DAYS_W-1:0]  s2_days_r;
  logic [TOD_W-1:0]   s2_tod_r;
  // output
  logic               out_valid_r;
  logic               out_status_r;
  logic [EPOCH_W-1:0] out_epoch_r;

  logic [13:0]        y4;
  logic [27:0]        q_prod;
  logic [DAYS_W:0]    days_sum;
  logic [41:0]        secs;

  assign y4     = in_item.year[15:2];
  assign q_prod = 28'(y4) * 28'(RECIP25);

  // 365y + y/4 - y/100 + y/400 + doy - shift, with y/400 = (y/100)/4
  assign days_sum = (DAYS_W+1)'(s1_d365_r) + (DAYS_W+1)'(s1_y4_r)
                  - (DAYS_W+1)'(s1_q100_r) + (DAYS_W+1)'(s1_q100_r[9:2])
                  + (DAYS_W+1)'(s1_doy_r) - (DAYS_W+1)'(EPOCH_SHIFT);

  assign secs = 42'(s2_days_r) * 42'(DAY_SECONDS) + 42'(s2_tod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r   <= in_item.ok;
    s1_y4_r   <= y4;
    s1_q100_r <= 10'(q_prod >> RECIP25_SH);
    s1_d365_r <= DAYS_W'(in_item.year) * DAYS_W'(DAYS_YEAR);
    s1_doy_r  <= in_item.doy;
    s1_tod_r  <= TOD_W'(in_item.hour) * TOD_W'(HOUR_SECONDS)
               + TOD_W'(in_item.minute) * TOD_W'(MIN_SECONDS)
               + TOD_W'(in_item.second);

    s2_ok_r   <= s1_ok_r;
    s2_days_r <= days_sum[DAYS_W-1:0];
    s2_tod_r  <= s1_tod_r;

    out_status_r <= !s2_ok_r;
    out_epoch_r  <= s2_ok_r ? secs[EPOCH_W-1:0] : '0;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_epoch_seconds = out_epoch_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##3 out_valid) else $error("result strobe missing");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid |-> ##3 !out_valid) else $error("spurious result strobe");
`endif

endmodule
